/* hdl/ugw_pkg.sv */
// Shared constants, types and helpers for the uniform grid ray walk block.
`default_nettype none
package ugw_pkg;

	localparam int GRID_MAX    = 16;
	localparam int LIST_BITS   = 20;
	localparam int TABLE_DEPTH = GRID_MAX * GRID_MAX * GRID_MAX + 1;
	localparam int MAX_RES     = 3 * GRID_MAX - 2;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_TRACE = 1'b1;

	localparam logic [2:0] REG_GRID_MIN_X  = 3'd0;
	localparam logic [2:0] REG_GRID_MIN_Y  = 3'd1;
	localparam logic [2:0] REG_GRID_MIN_Z  = 3'd2;
	localparam logic [2:0] REG_CELL_SIZE_X = 3'd3;
	localparam logic [2:0] REG_CELL_SIZE_Y = 3'd4;
	localparam logic [2:0] REG_CELL_SIZE_Z = 3'd5;
	localparam logic [2:0] REG_GRID_DIMS   = 3'd6;

	localparam logic signed [63:0] T_INF = 64'sh4000_0000_0000_0000;

	// status of a multi-cycle arithmetic unit
	typedef struct packed {
		logic busy;
		logic done;
	} ugw_unit_sts_t;

	// t + d, saturating at T_INF
	function automatic logic signed [63:0] sat_add(input logic signed [63:0] t,
		input logic signed [63:0] d);
		logic signed [63:0] s;
		s = t + d;
		if (t >= T_INF || d >= T_INF) return T_INF;
		return (s > T_INF) ? T_INF : s;
	endfunction

endpackage
`default_nettype wire

/* hdl/ugw_in_if.sv */
// Input channel: load and trace transactions.
`default_nettype none
interface ugw_in_if;
	logic               valid;
	logic               ready;
	logic               operation;
	logic [12:0]        entry_index;
	logic [19:0]        entry_value;
	logic signed [31:0] origin_x;
	logic signed [31:0] origin_y;
	logic signed [31:0] origin_z;
	logic signed [31:0] dir_x;
	logic signed [31:0] dir_y;
	logic signed [31:0] dir_z;
	logic [30:0]        t_limit;

	modport source (output valid, operation, entry_index, entry_value, origin_x, origin_y,
		origin_z, dir_x, dir_y, dir_z, t_limit, input ready);
	modport sink (input valid, operation, entry_index, entry_value, origin_x, origin_y,
		origin_z, dir_x, dir_y, dir_z, t_limit, output ready);
endinterface
`default_nettype wire

/* hdl/ugw_out_if.sv */
// Output channel: one transaction per visited cell or per miss.
`default_nettype none
interface ugw_out_if;
	logic        valid;
	logic        ready;
	logic [11:0] cell_index;
	logic [19:0] list_start;
	logic [19:0] list_end;
	logic [30:0] t_enter;
	logic        missed;
	logic        last;

	modport source (output valid, cell_index, list_start, list_end, t_enter, missed, last,
		input ready);
	modport sink (input valid, cell_index, list_start, list_end, t_enter, missed, last,
		output ready);
endinterface
`default_nettype wire

/* hdl/ugw_div.sv */
// Restoring divider, one quotient bit per cycle, truncates toward zero.
`default_nettype none
module ugw_div (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic signed [63:0]    num,
	input  wire logic signed [32:0]    den,
	output logic signed [63:0]         quo,
	output ugw_pkg::ugw_unit_sts_t     sts
);
	import ugw_pkg::*;

	logic        busy_q, done_q, neg_q;
	logic [5:0]  cnt_q;
	logic [32:0] rem_q;
	logic [32:0] dm_q;
	logic [63:0] qn_q;
	logic [63:0] num_mag;
	logic [32:0] den_mag;
	logic [33:0] trial;
	logic        fits;

	assign num_mag = num[63] ? (~num + 64'd1) : num;
	assign den_mag = den[32] ? (~den + 33'd1) : den;
	assign trial   = {rem_q, qn_q[63]};
	assign fits    = trial >= {1'b0, dm_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			neg_q  <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			dm_q   <= '0;
			qn_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				neg_q  <= num[63] ^ den[32];
				cnt_q  <= '0;
				rem_q  <= '0;
				dm_q   <= den_mag;
				qn_q   <= num_mag;
			end else if (busy_q) begin
				rem_q <= fits ? 33'(trial - {1'b0, dm_q}) : trial[32:0];
				qn_q  <= {qn_q[62:0], fits};
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign quo      = neg_q ? -$signed(qn_q) : $signed(qn_q);
	assign sts.busy = busy_q;
	assign sts.done = done_q;
endmodule
`default_nettype wire

/* hdl/ugw_mul.sv */
// Shift-add multiplier: (a * b) / 65536 truncated toward zero.
`default_nettype none
module ugw_mul (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic signed [63:0]    a,
	input  wire logic signed [31:0]    b,
	output logic signed [63:0]         prod,
	output ugw_pkg::ugw_unit_sts_t     sts
);
	import ugw_pkg::*;

	logic        busy_q, done_q, neg_q;
	logic [4:0]  cnt_q;
	logic [63:0] mc_q, acc_q;
	logic [31:0] mp_q;
	logic [63:0] scaled;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			neg_q  <= 1'b0;
			cnt_q  <= '0;
			mc_q   <= '0;
			mp_q   <= '0;
			acc_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				neg_q  <= a[63] ^ b[31];
				cnt_q  <= '0;
				mc_q   <= a[63] ? (~a + 64'd1) : a;
				mp_q   <= b[31] ? (~b + 32'd1) : b;
				acc_q  <= '0;
			end else if (busy_q) begin
				if (mp_q[0]) acc_q <= acc_q + mc_q;
				mc_q  <= {mc_q[62:0], 1'b0};
				mp_q  <= {1'b0, mp_q[31:1]};
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign scaled   = {16'd0, acc_q[63:16]};
	assign prod     = neg_q ? -$signed(scaled) : $signed(scaled);
	assign sts.busy = busy_q;
	assign sts.done = done_q;
endmodule
`default_nettype wire

/* hdl/uniform_grid_ray_walk_core.sv */
// Top level of the uniform grid ray walk: setup sequencer, offset table, cell walk.
`default_nettype none
// Usage:
//  item (sink): a load transaction writes one entry of the 4097-entry cell
//   offset table (index beyond the table is dropped).
//  A trace transaction starts a ray. The slab clip and cell setup run on one
//  shared divider and one multiplier: up to 15 divisions and 3 multiplies,
//  fewer when direction components are zero.
//  result (source): a miss gives one transaction with missed and last set.
//  A hit gives one transaction per visited cell (table read, output load,
//  handoff), up to 46 per ray; last marks the final one. A ray
//  whose entry t is already at the limit gives nothing.
//  Only one ray is in flight: item.ready is high only while the block is idle.
//  A stalled result simply holds; the walk waits on it.
//  Configuration: cfg_we/cfg_index/cfg_wdata write a register; the user must do so
//  only while idle (not enforced). Reset clears control state and restores register
//  defaults; the offset table is not cleared and must be loaded before use.
module uniform_grid_ray_walk_core (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_wdata,
	ugw_in_if.sink     item,
	ugw_out_if.source  result
);
	import ugw_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE, ST_SL_LO, ST_SL_LO_W, ST_SL_HI, ST_SL_HI_W, ST_CHECK, ST_MISS,
		ST_PO_MUL, ST_PO_MUL_W, ST_PO_CELL, ST_PO_CELL_W, ST_PO_DT, ST_PO_DT_W,
		ST_PO_TNX, ST_PO_TNX_W, ST_WALK_CHK, ST_RD, ST_OUT_LD, ST_EMIT
	} state_t;

	// configuration registers
	logic signed [31:0] gmin_q [3];
	logic [30:0]        csz_q  [3];
	logic [11:0]        dims_q;

	// ray state
	state_t             state_q;
	logic [1:0]         ax_q;
	logic signed [31:0] org_q [3];
	logic signed [31:0] dir_q [3];
	logic [30:0]        limit_q;
	logic               miss_q;
	logic signed [63:0] t1_q, tnear_q, tfar_q, off_q;
	logic signed [63:0] dt_q  [3];
	logic signed [63:0] tnx_q [3];
	logic [3:0]         cell_q [3];
	logic [5:0]         count_q;
	logic [1:0]         sel_q;
	logic [3:0]         ncell_q;
	logic               last_q;

	// result register
	logic               res_valid_q;
	logic [11:0]        res_cell_q;
	logic [19:0]        res_start_q, res_end_q;
	logic [30:0]        res_t_q;
	logic               res_missed_q;

	// offset table
	logic [LIST_BITS-1:0] table_mem [TABLE_DEPTH];
	logic [LIST_BITS-1:0] rd0_q, rd1_q;
	logic                 rd_en;

	// arithmetic units
	logic                 div_start, mul_start;
	logic signed [63:0]   div_num, div_quo, mul_prod;
	logic signed [32:0]   div_den;
	ugw_unit_sts_t        div_sts, mul_sts;

	// current-axis values
	logic signed [63:0] org_c, lo_c, hi_c, far_c;
	logic signed [31:0] dir_c;
	logic               dir_zero, dir_pos;
	logic [30:0]        cs_c;
	logic [4:0]         n_c, fc_c;
	logic [35:0]        span_c, far_span_c;
	logic [3:0]         c_clamp;

	// walk step
	logic [4:0]         n_ax [3];
	logic [1:0]         sel_c;
	logic signed [5:0]  nc_c, stop_c;
	logic               last_c;
	logic [12:0]        idx_c;
	logic signed [63:0] tmin_c, tmax_c;
	logic signed [63:0] limit_c;

	logic item_fire, load_fire;

	assign item_fire = item.valid && item.ready;
	assign load_fire = item_fire && (item.operation == OP_LOAD);
	assign limit_c   = $signed(64'(limit_q));

	always_comb begin
		for (int i = 0; i < 3; i++) n_ax[i] = 5'(dims_q[4*i +: 4]) + 5'd1;
	end

	// per-axis operands
	assign org_c    = 64'(org_q[ax_q]);
	assign dir_c    = dir_q[ax_q];
	assign dir_zero = (dir_c == 32'sd0);
	assign dir_pos  = !dir_c[31] && !dir_zero;
	assign lo_c     = 64'(gmin_q[ax_q]);
	assign cs_c     = (csz_q[ax_q] == '0) ? 31'd1 : csz_q[ax_q];
	assign n_c      = n_ax[ax_q];
	assign span_c   = n_c * cs_c;
	assign hi_c     = lo_c + $signed({28'd0, span_c});
	assign fc_c     = dir_pos ? (5'(cell_q[ax_q]) + 5'd1) : 5'(cell_q[ax_q]);
	assign far_span_c = fc_c * cs_c;
	assign far_c    = lo_c + $signed({28'd0, far_span_c});

	// clamp of the cell coordinate quotient to the grid
	always_comb begin
		if (div_quo < 0) c_clamp = '0;
		else if (div_quo > 64'(n_c - 5'd1)) c_clamp = 4'(n_c - 5'd1);
		else c_clamp = div_quo[3:0];
	end

	assign tmin_c = (t1_q < div_quo) ? t1_q : div_quo;
	assign tmax_c = (t1_q < div_quo) ? div_quo : t1_q;

	// divider / multiplier operand selection
	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = 33'(dir_c);
		mul_start = 1'b0;
		case (state_q)
			ST_SL_LO: begin
				div_start = !dir_zero;
				div_num   = (lo_c - org_c) <<< 16;
			end
			ST_SL_HI: begin
				div_start = 1'b1;
				div_num   = (hi_c - org_c) <<< 16;
			end
			ST_PO_MUL: mul_start = !dir_zero;
			ST_PO_CELL: begin
				div_start = 1'b1;
				div_num   = org_c + off_q - lo_c;
				div_den   = $signed({2'b00, cs_c});
			end
			ST_PO_DT: begin
				div_start = 1'b1;
				div_num   = $signed(64'(cs_c)) <<< 16;
				div_den   = dir_c[31] ? -33'(dir_c) : 33'(dir_c);
			end
			ST_PO_TNX: begin
				div_start = 1'b1;
				div_num   = (far_c - org_c) <<< 16;
			end
			default: ;
		endcase
	end

	ugw_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.quo    (div_quo),
		.sts    (div_sts)
	);

	ugw_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (tnear_q),
		.b      (dir_c),
		.prod   (mul_prod),
		.sts    (mul_sts)
	);

	// next step: x only on a strict minimum, y only strictly below z; ties go to the later axis
	always_comb begin
		if (tnx_q[0] < tnx_q[1] && tnx_q[0] < tnx_q[2]) sel_c = 2'd0;
		else if (tnx_q[1] < tnx_q[2]) sel_c = 2'd1;
		else sel_c = 2'd2;
		if (!dir_q[sel_c][31] && dir_q[sel_c] != 32'sd0) begin
			nc_c   = $signed({2'b00, cell_q[sel_c]}) + 6'sd1;
			stop_c = $signed({1'b0, n_ax[sel_c]});
		end else begin
			nc_c   = $signed({2'b00, cell_q[sel_c]}) - 6'sd1;
			stop_c = -6'sd1;
		end
		last_c = (nc_c == stop_c) || (tnx_q[sel_c] >= limit_c)
			|| (count_q == 6'(MAX_RES - 1));
	end

	assign idx_c = 13'((cell_q[0] * n_ax[1] + 13'(cell_q[1])) * n_ax[2]) + 13'(cell_q[2]);
	assign rd_en = (state_q == ST_RD);

	// offset table: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (load_fire && item.entry_index < 13'(TABLE_DEPTH))
			table_mem[item.entry_index] <= item.entry_value;
		if (rd_en) begin
			rd0_q <= table_mem[idx_c];
			rd1_q <= table_mem[idx_c + 13'd1];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				gmin_q[i] <= '0;
				csz_q[i]  <= 31'd65536;
			end
			dims_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GRID_MIN_X:  gmin_q[0] <= cfg_wdata;
				REG_GRID_MIN_Y:  gmin_q[1] <= cfg_wdata;
				REG_GRID_MIN_Z:  gmin_q[2] <= cfg_wdata;
				REG_CELL_SIZE_X: csz_q[0]  <= cfg_wdata[30:0];
				REG_CELL_SIZE_Y: csz_q[1]  <= cfg_wdata[30:0];
				REG_CELL_SIZE_Z: csz_q[2]  <= cfg_wdata[30:0];
				REG_GRID_DIMS:   dims_q    <= cfg_wdata[11:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ax_q         <= '0;
			limit_q      <= '0;
			miss_q       <= 1'b0;
			t1_q         <= '0;
			tnear_q      <= '0;
			tfar_q       <= '0;
			off_q        <= '0;
			count_q      <= '0;
			sel_q        <= '0;
			ncell_q      <= '0;
			last_q       <= 1'b0;
			res_valid_q  <= 1'b0;
			res_cell_q   <= '0;
			res_start_q  <= '0;
			res_end_q    <= '0;
			res_t_q      <= '0;
			res_missed_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				org_q[i]  <= '0;
				dir_q[i]  <= '0;
				dt_q[i]   <= '0;
				tnx_q[i]  <= '0;
				cell_q[i] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (item_fire && item.operation == OP_TRACE) begin
						org_q[0] <= item.origin_x;
						org_q[1] <= item.origin_y;
						org_q[2] <= item.origin_z;
						dir_q[0] <= item.dir_x;
						dir_q[1] <= item.dir_y;
						dir_q[2] <= item.dir_z;
						limit_q  <= item.t_limit;
						tnear_q  <= -T_INF;
						tfar_q   <= T_INF;
						miss_q   <= 1'b0;
						ax_q     <= '0;
						state_q  <= ST_SL_LO;
					end
				end
				ST_SL_LO: begin
					if (dir_zero) begin
						if (org_c < lo_c || org_c > hi_c) miss_q <= 1'b1;
						if (ax_q == 2'd2) state_q <= ST_CHECK;
						else ax_q <= ax_q + 2'd1;
					end else begin
						state_q <= ST_SL_LO_W;
					end
				end
				ST_SL_LO_W: begin
					if (div_sts.done) begin
						t1_q    <= div_quo;
						state_q <= ST_SL_HI;
					end
				end
				ST_SL_HI: state_q <= ST_SL_HI_W;
				ST_SL_HI_W: begin
					if (div_sts.done) begin
						if (tmin_c > tnear_q) tnear_q <= tmin_c;
						if (tmax_c < tfar_q) tfar_q <= tmax_c;
						if (ax_q == 2'd2) begin
							state_q <= ST_CHECK;
						end else begin
							ax_q    <= ax_q + 2'd1;
							state_q <= ST_SL_LO;
						end
					end
				end
				ST_CHECK: begin
					if (miss_q || tnear_q >= tfar_q || tfar_q < 64'sd1) begin
						res_valid_q  <= 1'b1;
						res_cell_q   <= '0;
						res_start_q  <= '0;
						res_end_q    <= '0;
						res_t_q      <= '0;
						res_missed_q <= 1'b1;
						last_q       <= 1'b1;
						state_q      <= ST_MISS;
					end else begin
						if (tnear_q < 0) tnear_q <= '0;
						ax_q    <= '0;
						state_q <= ST_PO_MUL;
					end
				end
				ST_MISS: begin
					if (result.ready) begin
						res_valid_q <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				ST_PO_MUL: begin
					if (dir_zero) begin
						off_q   <= '0;
						state_q <= ST_PO_CELL;
					end else begin
						state_q <= ST_PO_MUL_W;
					end
				end
				ST_PO_MUL_W: begin
					if (mul_sts.done) begin
						off_q   <= mul_prod;
						state_q <= ST_PO_CELL;
					end
				end
				ST_PO_CELL: state_q <= ST_PO_CELL_W;
				ST_PO_CELL_W: begin
					if (div_sts.done) begin
						cell_q[ax_q] <= c_clamp;
						if (dir_zero) begin
							dt_q[ax_q]  <= T_INF;
							tnx_q[ax_q] <= T_INF;
							if (ax_q == 2'd2) begin
								state_q <= ST_WALK_CHK;
							end else begin
								ax_q    <= ax_q + 2'd1;
								state_q <= ST_PO_MUL;
							end
						end else begin
							state_q <= ST_PO_DT;
						end
					end
				end
				ST_PO_DT: state_q <= ST_PO_DT_W;
				ST_PO_DT_W: begin
					if (div_sts.done) begin
						dt_q[ax_q] <= div_quo;
						state_q    <= ST_PO_TNX;
					end
				end
				ST_PO_TNX: state_q <= ST_PO_TNX_W;
				ST_PO_TNX_W: begin
					if (div_sts.done) begin
						tnx_q[ax_q] <= div_quo;
						if (ax_q == 2'd2) begin
							state_q <= ST_WALK_CHK;
						end else begin
							ax_q    <= ax_q + 2'd1;
							state_q <= ST_PO_MUL;
						end
					end
				end
				ST_WALK_CHK: begin
					count_q <= '0;
					if (tnear_q < limit_c) state_q <= ST_RD;
					else state_q <= ST_IDLE;
				end
				ST_RD: state_q <= ST_OUT_LD;
				ST_OUT_LD: begin
					res_valid_q  <= 1'b1;
					res_cell_q   <= idx_c[11:0];
					res_start_q  <= rd0_q;
					res_end_q    <= rd1_q;
					res_t_q      <= (tnear_q < 0) ? '0 : tnear_q[30:0];
					res_missed_q <= 1'b0;
					last_q       <= last_c;
					sel_q        <= sel_c;
					ncell_q      <= nc_c[3:0];
					state_q      <= ST_EMIT;
				end
				ST_EMIT: begin
					if (result.ready) begin
						res_valid_q <= 1'b0;
						if (last_q) begin
							state_q <= ST_IDLE;
						end else begin
							cell_q[sel_q] <= ncell_q;
							tnear_q       <= tnx_q[sel_q];
							tnx_q[sel_q]  <= sat_add(tnx_q[sel_q], dt_q[sel_q]);
							count_q       <= count_q + 6'd1;
							state_q       <= ST_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign item.ready        = (state_q == ST_IDLE);
	assign result.valid      = res_valid_q;
	assign result.cell_index = res_cell_q;
	assign result.list_start = res_start_q;
	assign result.list_end   = res_end_q;
	assign result.t_enter    = res_t_q;
	assign result.missed     = res_missed_q;
	assign result.last       = last_q;

	// one ray at a time: never a pending result while taking input
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(result.valid && item.ready))
		else $error("result pending while input is ready");

	// a miss is a single, empty result
	a_miss_single: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.missed |-> result.last && result.cell_index == '0)
		else $error("miss result not final or not empty");

	// divider is never restarted mid-operation
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_sts.busy)
		else $error("divider started while busy");

	// multiplier result only arrives while the sequencer waits for it
	a_mul_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mul_sts.done |-> state_q == ST_PO_MUL_W)
		else $error("multiplier done outside its wait state");
endmodule
`default_nettype wire

/* verif/ugw_walk_checker.sv */
// Checker for the grid ray walk: watches both channels, predicts the visited cells, compares.
`default_nettype none
module ugw_walk_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_wdata,
	ugw_in_if                item,
	ugw_out_if               result,
	output int               errors,
	output int               outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import ugw_pkg::*;

	typedef struct packed {
		logic [11:0] cell_index;
		logic [19:0] list_start;
		logic [19:0] list_end;
		logic [30:0] t_enter;
		logic        missed;
		logic        last;
	} cell_visit_t;

	localparam longint Q_ONE = 65536;
	localparam longint T_BIG = longint'(1) << 62;

	logic [19:0] offset_table [TABLE_DEPTH];
	bit          entry_written [TABLE_DEPTH];
	longint      box_lo [3];
	longint      cell_edge [3];
	logic [11:0] dims;
	cell_visit_t visits_due [$];
	bit [1:0]    known_due [$]; // list_start, list_end come from written entries

	assign outstanding = visits_due.size();

	function automatic longint t_sum(input longint t, input longint d);
		longint s;
		if (t >= T_BIG || d >= T_BIG) return T_BIG;
		s = t + d;
		return (s > T_BIG) ? T_BIG : s;
	endfunction

	// Clip the ray to the box, then walk the cells and queue one visit per cell, or a single miss visit.
	task automatic walk_ray(input longint org [3], input longint dir [3], input longint lim);
		longint lo [3], hi [3], cs [3], n [3], dt [3], tnx [3], cell_at [3], stp [3];
		longint stop_at [3];
		longint tnear, tfar, t1, t2, sw, off, c, fr, ad, idx;
		bit     miss;
		int     a, count;
		cell_visit_t v;
		tnear = -T_BIG;
		tfar  = T_BIG;
		miss  = 0;
		count = 0;
		for (a = 0; a < 3; a++) begin
			lo[a] = box_lo[a];
			cs[a] = (cell_edge[a] == 0) ? 1 : cell_edge[a];
			n[a]  = longint'(dims[4*a +: 4]) + 1;
			hi[a] = lo[a] + n[a] * cs[a];
			if (dir[a] == 0) begin
				if (org[a] < lo[a] || org[a] > hi[a])
					miss = 1;
			end else begin
				t1 = ((lo[a] - org[a]) * Q_ONE) / dir[a];
				t2 = ((hi[a] - org[a]) * Q_ONE) / dir[a];
				if (t1 > t2) begin
					sw = t1; t1 = t2; t2 = sw;
				end
				if (t1 > tnear) tnear = t1;
				if (t2 < tfar) tfar = t2;
			end
		end
		if (miss || tnear >= tfar || tfar < 1) begin
			v = '0;
			v.missed = 1;
			v.last = 1;
			visits_due.push_back(v);
			known_due.push_back(2'b11);
			return;
		end
		if (tnear < 0) tnear = 0;
		for (a = 0; a < 3; a++) begin
			off = (dir[a] == 0) ? 0 : (tnear * dir[a]) / Q_ONE;
			c = (org[a] + off - lo[a]) / cs[a];
			if (c < 0) c = 0;
			if (c > n[a] - 1) c = n[a] - 1;
			cell_at[a] = c;
			stp[a] = (dir[a] > 0) ? 1 : -1;
			stop_at[a] = (dir[a] > 0) ? n[a] : -1;
			if (dir[a] == 0) begin
				dt[a] = T_BIG;
				tnx[a] = T_BIG;
			end else begin
				ad = (dir[a] < 0) ? -dir[a] : dir[a];
				dt[a] = (cs[a] * Q_ONE) / ad;
				fr = ((dir[a] > 0) ? c + 1 : c) * cs[a] + lo[a];
				tnx[a] = ((fr - org[a]) * Q_ONE) / dir[a];
			end
		end
		while (tnear < lim && count < MAX_RES) begin
			idx = (cell_at[0] * n[1] + cell_at[1]) * n[2] + cell_at[2];
			v.cell_index = idx[11:0];
			v.list_start = offset_table[idx];
			v.list_end   = offset_table[idx + 1];
			v.t_enter    = tnear[30:0];
			v.missed     = 0;
			v.last       = 0;
			visits_due.push_back(v);
			known_due.push_back({entry_written[idx], entry_written[idx + 1]});
			count++;
			// x only on a strict minimum, y only strictly below z; ties go to the later axis
			if (tnx[0] < tnx[1] && tnx[0] < tnx[2]) a = 0;
			else if (tnx[1] < tnx[2]) a = 1;
			else a = 2;
			cell_at[a] += stp[a];
			if (cell_at[a] == stop_at[a]) break;
			tnear = tnx[a];
			tnx[a] = t_sum(tnx[a], dt[a]);
		end
		if (count > 0) visits_due[$].last = 1;
	endtask

	initial begin
		errors = 0;
		foreach (offset_table[i]) offset_table[i] = '0;
		foreach (entry_written[i]) entry_written[i] = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		longint org [3], dir [3];
		cell_visit_t got, want;
		bit [1:0] known;
		if (!arst_n) begin
			box_lo = '{0, 0, 0};
			cell_edge = '{Q_ONE, Q_ONE, Q_ONE};
			dims = '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_GRID_MIN_X:  box_lo[0] = longint'($signed(cfg_wdata));
					REG_GRID_MIN_Y:  box_lo[1] = longint'($signed(cfg_wdata));
					REG_GRID_MIN_Z:  box_lo[2] = longint'($signed(cfg_wdata));
					REG_CELL_SIZE_X: cell_edge[0] = longint'(cfg_wdata[30:0]);
					REG_CELL_SIZE_Y: cell_edge[1] = longint'(cfg_wdata[30:0]);
					REG_CELL_SIZE_Z: cell_edge[2] = longint'(cfg_wdata[30:0]);
					REG_GRID_DIMS:   dims = cfg_wdata[11:0];
					default: ;
				endcase
			end
			if (result.valid && result.ready) begin
				got = '{result.cell_index, result.list_start, result.list_end,
					result.t_enter, result.missed, result.last};
				if (visits_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected result transaction, actual %p", $time, got);
				end else begin
					want = visits_due.pop_front();
					known = known_due.pop_front();
					if (got.cell_index !== want.cell_index ||
						(known[1] && got.list_start !== want.list_start) ||
						(known[0] && got.list_end !== want.list_end) ||
						got.t_enter !== want.t_enter ||
						got.missed !== want.missed || got.last !== want.last) begin
						errors++;
						$display("%0t: result mismatch, expected %p, actual %p", $time, want, got);
					end
				end
			end
			if (item.valid && item.ready) begin
				if (item.operation == OP_LOAD) begin
					if (item.entry_index < TABLE_DEPTH) begin
						offset_table[item.entry_index] = item.entry_value;
						entry_written[item.entry_index] = 1;
					end
				end else begin
					org = '{longint'(item.origin_x), longint'(item.origin_y),
						longint'(item.origin_z)};
					dir = '{longint'(item.dir_x), longint'(item.dir_y), longint'(item.dir_z)};
					walk_ray(org, dir, longint'(item.t_limit));
				end
			end
		end
	end
endmodule
`default_nettype wire

/* verif/tb.sv */
// Testbench top: clock, reset, register setup, load and trace stimulus, verdict.
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ugw_pkg::*;

	localparam longint Q_ONE = 65536;
	localparam int     IDLE_LIMIT = 20000;  // above the longest setup; stalls are short
	localparam int     DRAIN_CYCLES = 1500; // a silent ray still occupies the setup
	localparam int     RANDOM_ITEMS = 250;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_wdata = '0;
	int          errors, outstanding, idle_cnt;
	bit          quiet = 0; // no idling on either side

	// local copy of the geometry, used to aim random rays at the box
	longint cur_lo [3] = '{0, 0, 0};
	longint cur_cs [3] = '{Q_ONE, Q_ONE, Q_ONE};
	longint cur_n [3] = '{1, 1, 1};

	ugw_in_if  item ();
	ugw_out_if result ();

	uniform_grid_ray_walk_core u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .item(item), .result(result)
	);

	ugw_walk_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .item(item), .result(result),
		.errors(errors), .outstanding(outstanding)
	);

	always #2 clk = ~clk;

	initial begin
		item.valid = 0;
		item.operation = OP_LOAD;
		item.entry_index = '0;
		item.entry_value = '0;
		item.origin_x = '0;
		item.origin_y = '0;
		item.origin_z = '0;
		item.dir_x = '0;
		item.dir_y = '0;
		item.dir_z = '0;
		item.t_limit = '0;
		result.ready = 0;
	end

	// Watchdog: counts cycles with no transaction on either channel.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item.valid && item.ready) || (result.valid && result.ready))
				idle_cnt <= 0;
			else
				idle_cnt <= idle_cnt + 1;
			if (idle_cnt >= IDLE_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end else begin
			idle_cnt <= 0;
		end
	end

	// Result side: bursts of ready and stall, steady ready once quiet.
	initial begin
		int k;
		@(posedge clk iff arst_n);
		forever begin
			if (quiet || $urandom_range(0, 3) == 0) begin
				result.ready <= 1;
				k = $urandom_range(1, 40);
			end else begin
				result.ready <= ~result.ready;
				k = $urandom_range(1, 19);
			end
			repeat (k) @(posedge clk);
		end
	end

	// Write enable stays up across back-to-back writes; the caller drops it.
	task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			REG_GRID_MIN_X:  cur_lo[0] = longint'($signed(data));
			REG_GRID_MIN_Y:  cur_lo[1] = longint'($signed(data));
			REG_GRID_MIN_Z:  cur_lo[2] = longint'($signed(data));
			REG_CELL_SIZE_X: cur_cs[0] = longint'(data[30:0]);
			REG_CELL_SIZE_Y: cur_cs[1] = longint'(data[30:0]);
			REG_CELL_SIZE_Z: cur_cs[2] = longint'(data[30:0]);
			REG_GRID_DIMS:   cur_n = '{data[3:0] + 1, data[7:4] + 1, data[11:8] + 1};
			default: ;
		endcase
	endtask

	// Wait until every expected result is in and the setup of a silent ray is done.
	task automatic wait_idle();
		item.valid <= 0;
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_geometry(input longint lo [3], input longint cs [3],
		input logic [11:0] d);
		wait_idle();
		cfg_write(REG_GRID_MIN_X, lo[0][31:0]);
		cfg_write(REG_GRID_MIN_Y, lo[1][31:0]);
		cfg_write(REG_GRID_MIN_Z, lo[2][31:0]);
		cfg_write(REG_CELL_SIZE_X, cs[0][31:0]);
		cfg_write(REG_CELL_SIZE_Y, cs[1][31:0]);
		cfg_write(REG_CELL_SIZE_Z, cs[2][31:0]);
		cfg_write(REG_GRID_DIMS, {20'd0, d});
		cfg_we <= 0;
	endtask

	// Holds valid until the transaction is taken; ready is sampled mid-cycle.
	// Valid stays up into the next transaction unless an idle gap follows.
	task automatic handshake();
		item.valid <= 1;
		do @(negedge clk); while (!item.ready);
		@(posedge clk);
		if (!quiet && $urandom_range(0, 2) == 0) begin
			item.valid <= 0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	task automatic send_load(input logic [12:0] idx, input logic [19:0] val);
		item.operation <= OP_LOAD;
		item.entry_index <= idx;
		item.entry_value <= val;
		handshake();
	endtask

	task automatic send_trace(input longint ox, input longint oy, input longint oz,
		input longint dx, input longint dy, input longint dz, input logic [30:0] lim);
		item.operation <= OP_TRACE;
		item.origin_x <= ox[31:0];
		item.origin_y <= oy[31:0];
		item.origin_z <= oz[31:0];
		item.dir_x <= dx[31:0];
		item.dir_y <= dy[31:0];
		item.dir_z <= dz[31:0];
		item.t_limit <= lim;
		handshake();
	endtask

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// Mostly inside the box or just around it, sometimes anywhere.
	function automatic longint pick_origin(input int a);
		longint unsigned r;
		longint span;
		if ($urandom_range(0, 5) == 0)
			return longint'($signed($urandom));
		span = cur_n[a] * cur_cs[a] + 2 * cur_cs[a];
		r = {$urandom, $urandom};
		return clamp32(cur_lo[a] - cur_cs[a] + longint'(r % longint'(span + 1)));
	endfunction

	function automatic longint pick_dir();
		longint m;
		case ($urandom_range(0, 7))
			0:       return 0;
			1, 2:    return longint'($signed($urandom));
			3:       m = $urandom_range(1, 255);
			default: m = $urandom_range(1, 4 * 65536);
		endcase
		return $urandom_range(0, 1) ? m : -m;
	endfunction

	function automatic logic [30:0] pick_limit();
		case ($urandom_range(0, 9))
			0, 1, 2: return 31'($urandom);
			3, 4:    return 31'($urandom_range(0, 16 * 65536));
			default: return 31'h7FFF_FFFF;
		endcase
	endfunction

	initial begin
		int i;
		longint lo [3], cs [3];
		logic [11:0] d;

		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed, reset geometry: one unit cell at the origin.
		send_load(13'd4096, 20'hFFFFF);     // last table entry
		send_load(13'h1FFF, 20'h12345);     // beyond the table, dropped
		send_load(13'd0, 20'h00000);
		send_trace(Q_ONE / 2, Q_ONE / 2, -Q_ONE, 0, 0, Q_ONE, 31'h7FFF_FFFF);
		// zero direction with the origin outside that slab: miss
		send_trace(2 * Q_ONE, Q_ONE / 2, Q_ONE / 2, 0, 0, Q_ONE, 31'h7FFF_FFFF);
		// box entirely behind the ray: miss
		send_trace(2 * Q_ONE, Q_ONE / 2, Q_ONE / 2, Q_ONE, 0, 0, 31'h7FFF_FFFF);
		// entry already at the limit: nothing comes back
		send_trace(Q_ONE / 2, Q_ONE / 2, Q_ONE / 2, Q_ONE, 0, 0, 31'd0);
		send_trace(64'sd2147483647, -64'sd2147483648, 0,
			-64'sd2147483648, 64'sd2147483647, 1, 31'h7FFF_FFFF);
		send_trace(0, 0, 0, 0, 0, 0, 31'h7FFF_FFFF);

		// Directed, 4x4x4 unit grid: ties, reverse walk, tiny directions, limits.
		lo = '{0, 0, 0};
		cs = '{Q_ONE, Q_ONE, Q_ONE};
		set_geometry(lo, cs, 12'h333);
		send_trace(0, 0, 0, Q_ONE, Q_ONE, Q_ONE, 31'h7FFF_FFFF);
		send_trace(4 * Q_ONE, 4 * Q_ONE, 4 * Q_ONE, -Q_ONE, -Q_ONE, -Q_ONE, 31'h7FFF_FFFF);
		send_trace(Q_ONE / 3, 0, 0, Q_ONE, Q_ONE, 0, 31'h7FFF_FFFF);
		send_trace(-Q_ONE, Q_ONE / 2, Q_ONE / 2, 1, 0, 0, 31'h7FFF_FFFF);
		send_trace(-Q_ONE, Q_ONE + 5, 2 * Q_ONE + 7, Q_ONE, 3 * Q_ONE / 7, -Q_ONE / 5,
			31'(2 * Q_ONE));
		send_trace(-2 * Q_ONE, 2 * Q_ONE, 2 * Q_ONE, -Q_ONE, 0, 0, 31'h7FFF_FFFF);
		send_trace(Q_ONE / 2, Q_ONE / 2, -Q_ONE, 0, 0, 64'sd2147483647, 31'd1);
		send_trace(Q_ONE, Q_ONE, Q_ONE, -64'sd2147483648, -1, 64'sd2147483647,
			31'h7FFF_FFFF);

		// Random phases across several geometries, extremes among them.
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			case (i)
				0: begin
					lo = '{-3 * Q_ONE, -2 * Q_ONE, -3 * Q_ONE / 2};
					cs = '{2 * Q_ONE, Q_ONE / 2, Q_ONE};
					set_geometry(lo, cs, 12'h5A3);
				end
				60: begin
					lo = '{0, 0, 0};
					cs = '{Q_ONE / 4, Q_ONE / 4, Q_ONE / 4};
					set_geometry(lo, cs, 12'hFFF);
				end
				120: begin
					lo = '{-64'sd2147483648, 64'sd2147483647, 12345};
					cs = '{64'sd2147483647, 1, 3 * Q_ONE};
					set_geometry(lo, cs, 12'hF0F);
				end
				180: begin
					lo = '{Q_ONE, -Q_ONE, 0};
					cs = '{1, 3 * Q_ONE, 3 * Q_ONE / 4};
					set_geometry(lo, cs, 12'h1F7);
				end
				default: ;
			endcase
			if (i >= RANDOM_ITEMS - 30)
				quiet = 1;
			if ($urandom_range(0, 4) == 0)
				send_load(13'($urandom), 20'($urandom));
			else
				send_trace(pick_origin(0), pick_origin(1), pick_origin(2),
					pick_dir(), pick_dir(), pick_dir(), pick_limit());
		end

		wait_idle();
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
`default_nettype wire

/* files.f */
hdl/ugw_pkg.sv
hdl/ugw_in_if.sv
hdl/ugw_out_if.sv
hdl/ugw_div.sv
hdl/ugw_mul.sv
hdl/uniform_grid_ray_walk_core.sv
verif/ugw_walk_checker.sv
verif/tb.sv
